>>> design/smas_pkg.sv
// Shared types, sizes and codes for the small matrix add/subtract/multiply block.
// Used by smas_front, smas_cmd_fifo, smas_back and small_matrix_add_sub_mul.
// No dependencies.
`default_nettype none

package smas_pkg;

  // Matrix dimensions and element width.
  localparam int unsigned SIZE          = 3;
  localparam int unsigned ELEMENT_WIDTH = 16;
  localparam int unsigned CELLS         = SIZE * SIZE;

  // Port widths fixed by the interface.
  localparam int unsigned IN_W    = 16;
  localparam int unsigned VALUE_W = 33;
  localparam int unsigned ROW_W   = 3;

  // Derived index widths.
  localparam int unsigned IDX_W  = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int unsigned CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned PROD_W = 2 * ELEMENT_WIDTH;

  // Command queue between the front and the back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_SUB     = 2'd1,
    MODE_MUL     = 2'd2,
    MODE_MUL_ALT = 2'd3
  } mode_e;

  typedef enum logic {
    BACK_IDLE = 1'b0,
    BACK_RUN  = 1'b1
  } back_state_e;

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic signed [PROD_W-1:0]        prod_t;
  typedef logic signed [VALUE_W-1:0]       value_t;
  typedef logic [IDX_W-1:0]                idx_t;
  typedef logic [CELL_W-1:0]               cell_t;

  // Store write from the front into the element banks of the back.
  typedef struct packed {
    logic  en;
    logic  bank;
    cell_t addr;
    elem_t a;
    elem_t b;
  } store_wr_t;

  // One queued frame: operation and the bank that holds its operands.
  typedef struct packed {
    mode_e mode;
    logic  bank;
  } cmd_t;

  // Back tells the front that a bank has been fully read.
  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage

`default_nettype wire

>>> design/small_matrix_add_sub_mul.sv
// Top level of the small matrix add/subtract/multiply block.
// Connects smas_front, smas_cmd_fifo and smas_back; depends on smas_pkg.
//
// Usage: send one word per matrix position in row-major order; each word
// carries the A and B elements of that position. The mode of the ninth word
// of a frame picks the operation: add, subtract, or matrix product.
// The block then returns nine result words in row-major order with row,
// column and a last flag on the final one.
// Input is taken one word per cycle. Two operand banks let the next frame load
// while the previous one is computed; input stalls only when both banks wait.
// The back end steps one result cell at a time through one shared
// multiply-accumulate unit: an add or subtract cell is a single step, a
// product cell accumulates SIZE terms, and a frame begins from the idle state.
// When the receiver stalls, the output register holds its word and the
// sequencer waits before the next result word; the front keeps loading until
// both banks are full.
// Reset clears the load counter, the queue and the sequencer; bank contents
// are not cleared.
`default_nettype none

module small_matrix_add_sub_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] a_element_i,
  input  wire logic [15:0] b_element_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [32:0] value_o,
  output      logic [2:0]  row_o,
  output      logic [2:0]  col_o,
  output      logic        last_o
);

  smas_pkg::store_wr_t wr;
  smas_pkg::cmd_t      push_cmd, head_cmd;
  smas_pkg::done_t     done;
  logic                q_push, q_pop, q_full, q_empty;

  // Word intake and bank assignment.
  smas_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .a_element_i (a_element_i),
    .b_element_i (b_element_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd),
    .wr_o        (wr),
    .done_i      (done)
  );

  // Frame commands waiting for the back end.
  smas_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  // Operand banks, arithmetic and result output.
  smas_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .row_o       (row_o),
    .col_o       (col_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

>>> design/smas_front.sv
// Front end: accepts element words, assigns them to a store bank and slot,
// and queues one command per complete frame. Depends on smas_pkg.
`default_nettype none

module smas_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [15:0]          a_element_i,
  input  wire logic [15:0]          b_element_i,
  input  wire logic                 q_full_i,
  output      logic                 q_push_o,
  output      smas_pkg::cmd_t       q_cmd_o,
  output      smas_pkg::store_wr_t  wr_o,
  input  wire smas_pkg::done_t      done_i
);

  smas_pkg::cell_t load_q, load_d;
  logic            wbank_q, wbank_d;
  logic [1:0]      busy_q, busy_d;
  logic            accept;
  logic            last_item;

  // A bank the back has not yet fully read, or a full queue, holds off input.
  assign in_stall_o = busy_q[wbank_q] | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign last_item  = (load_q == smas_pkg::cell_t'(smas_pkg::CELLS - 1));

  // Element writes into the current bank.
  always_comb begin
    wr_o.en   = accept;
    wr_o.bank = wbank_q;
    wr_o.addr = load_q;
    wr_o.a    = smas_pkg::elem_t'($unsigned(a_element_i));
    wr_o.b    = smas_pkg::elem_t'($unsigned(b_element_i));
  end

  // The final word of a frame queues the command and flips banks.
  assign q_push_o      = accept & last_item;
  assign q_cmd_o.mode  = smas_pkg::mode_e'(mode_i);
  assign q_cmd_o.bank  = wbank_q;

  always_comb begin
    load_d  = load_q;
    wbank_d = wbank_q;
    busy_d  = busy_q;
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (accept) begin
      if (last_item) begin
        load_d          = '0;
        wbank_d         = ~wbank_q;
        busy_d[wbank_q] = 1'b1;
      end else begin
        load_d = load_q + smas_pkg::cell_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q  <= '0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      load_q  <= load_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

`default_nettype wire

>>> design/smas_cmd_fifo.sv
// Short command queue between the front end and the arithmetic back end.
// Depends on smas_pkg for the command type and the queue depth.
`default_nettype none

module smas_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire smas_pkg::cmd_t  cmd_i,
  output      logic            full_o,
  input  wire logic            pop_i,
  output      logic            empty_o,
  output      smas_pkg::cmd_t  cmd_o
);

  smas_pkg::cmd_t                  mem_q [smas_pkg::QDEPTH];
  logic [smas_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [smas_pkg::QCNT_W-1:0]     count_q;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == smas_pkg::QCNT_W'(smas_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == smas_pkg::QPTR_W'(smas_pkg::QDEPTH - 1)) ?
                    '0 : wr_ptr_q + smas_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == smas_pkg::QPTR_W'(smas_pkg::QDEPTH - 1)) ?
                    '0 : rd_ptr_q + smas_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + smas_pkg::QCNT_W'(1);
      end else if (!do_push && do_pop) begin
        count_q <= count_q - smas_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/smas_back.sv
// Back end: two element banks, a sequencer over result cells and a shared
// multiply-accumulate unit feeding an output register. Depends on smas_pkg.
`default_nettype none

module smas_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire smas_pkg::store_wr_t  wr_i,
  input  wire logic                 q_empty_i,
  input  wire smas_pkg::cmd_t       q_cmd_i,
  output      logic                 q_pop_o,
  output      smas_pkg::done_t      done_o,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [32:0]          value_o,
  output      logic [2:0]           row_o,
  output      logic [2:0]           col_o,
  output      logic                 last_o
);

  smas_pkg::elem_t        a_mem_q [2][smas_pkg::CELLS];
  smas_pkg::elem_t        b_mem_q [2][smas_pkg::CELLS];

  smas_pkg::back_state_e  state_q, state_d;
  smas_pkg::cmd_t         cmd_q;
  smas_pkg::idx_t         r_q, c_q, k_q;
  smas_pkg::value_t       acc_q;

  logic                   out_valid_q;
  smas_pkg::value_t       value_q;
  smas_pkg::idx_t         row_q, col_q;
  logic                   last_q;

  logic                   is_mul, sub_op;
  smas_pkg::cell_t        a_addr, b_addr;
  smas_pkg::elem_t        a_rd, b_rd;
  smas_pkg::prod_t        prod;
  smas_pkg::value_t       mac, result;
  logic                   last_k, last_c, last_r, last_cell;
  logic                   emit, out_free, step, start;

  // Element banks: one write port from the front, one read each for A and B.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      a_mem_q[wr_i.bank][wr_i.addr] <= wr_i.a;
      b_mem_q[wr_i.bank][wr_i.addr] <= wr_i.b;
    end
  end

  // Operation decode.
  always_comb begin
    unique case (cmd_q.mode)
      smas_pkg::MODE_ADD: begin
        is_mul = 1'b0;
        sub_op = 1'b0;
      end
      smas_pkg::MODE_SUB: begin
        is_mul = 1'b0;
        sub_op = 1'b1;
      end
      smas_pkg::MODE_MUL, smas_pkg::MODE_MUL_ALT: begin
        is_mul = 1'b1;
        sub_op = 1'b0;
      end
      default: begin
        is_mul = 1'b1;
        sub_op = 1'b0;
      end
    endcase
  end

  // Operand addresses: same cell for elementwise, row of A by column of B for product.
  assign a_addr = is_mul ? smas_pkg::cell_t'(r_q * smas_pkg::SIZE + k_q)
                         : smas_pkg::cell_t'(r_q * smas_pkg::SIZE + c_q);
  assign b_addr = is_mul ? smas_pkg::cell_t'(k_q * smas_pkg::SIZE + c_q)
                         : smas_pkg::cell_t'(r_q * smas_pkg::SIZE + c_q);
  assign a_rd   = a_mem_q[cmd_q.bank][a_addr];
  assign b_rd   = b_mem_q[cmd_q.bank][b_addr];

  // Shared arithmetic: one multiply-accumulate step, or one add or subtract.
  assign prod = smas_pkg::prod_t'(a_rd) * smas_pkg::prod_t'(b_rd);
  assign mac  = ((k_q == '0) ? smas_pkg::value_t'(0) : acc_q) + smas_pkg::value_t'(prod);

  always_comb begin
    if (is_mul) begin
      result = mac;
    end else if (sub_op) begin
      result = smas_pkg::value_t'(a_rd) - smas_pkg::value_t'(b_rd);
    end else begin
      result = smas_pkg::value_t'(a_rd) + smas_pkg::value_t'(b_rd);
    end
  end

  // Sequencing conditions.
  assign last_k    = (k_q == smas_pkg::idx_t'(smas_pkg::SIZE - 1));
  assign last_c    = (c_q == smas_pkg::idx_t'(smas_pkg::SIZE - 1));
  assign last_r    = (r_q == smas_pkg::idx_t'(smas_pkg::SIZE - 1));
  assign last_cell = last_r & last_c;
  assign emit      = ~is_mul | last_k;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign step      = (state_q == smas_pkg::BACK_RUN) & (~emit | out_free);
  assign start     = (state_q == smas_pkg::BACK_IDLE) & ~q_empty_i;

  assign q_pop_o      = start;
  assign done_o.valid = step & emit & last_cell;
  assign done_o.bank  = cmd_q.bank;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      smas_pkg::BACK_IDLE: begin
        if (start) begin
          state_d = smas_pkg::BACK_RUN;
        end
      end
      smas_pkg::BACK_RUN: begin
        if (step && emit && last_cell) begin
          state_d = smas_pkg::BACK_IDLE;
        end
      end
      default: state_d = smas_pkg::BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smas_pkg::BACK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Cell and term counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      c_q <= '0;
      k_q <= '0;
    end else if (start) begin
      r_q <= '0;
      c_q <= '0;
      k_q <= '0;
    end else if (step) begin
      if (is_mul && !last_k) begin
        k_q <= k_q + smas_pkg::idx_t'(1);
      end else begin
        k_q <= '0;
        if (last_c) begin
          c_q <= '0;
          r_q <= last_r ? '0 : r_q + smas_pkg::idx_t'(1);
        end else begin
          c_q <= c_q + smas_pkg::idx_t'(1);
        end
      end
    end
  end

  // Command and accumulator payload.
  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= q_cmd_i;
    end
    if (step) begin
      acc_q <= mac;
    end
  end

  // Output register; holds its word while the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      value_q <= result;
      row_q   <= r_q;
      col_q   <= c_q;
      last_q  <= last_cell;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign row_o       = smas_pkg::ROW_W'(row_q);
  assign col_o       = smas_pkg::ROW_W'(col_q);
  assign last_o      = last_q;

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for small_matrix_add_sub_mul: drives element-pair frames and
// compares every result word with an in-bench prediction of add, subtract and product.
// Depends on smas_pkg and the design under test only.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_FRAMES = 15;
  localparam int unsigned HOLD_CYCLES  = 300;

  localparam smas_pkg::elem_t ELEM_MAX = {1'b0, {(smas_pkg::ELEMENT_WIDTH-1){1'b1}}};
  localparam smas_pkg::elem_t ELEM_MIN = {1'b1, {(smas_pkg::ELEMENT_WIDTH-1){1'b0}}};

  typedef smas_pkg::elem_t frame_t [smas_pkg::CELLS];

  // One expected result word of the output channel.
  typedef struct {
    smas_pkg::value_t value;
    logic [2:0]       row;
    logic [2:0]       col;
    logic             last;
  } cell_word_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  smas_pkg::mode_e  mode      = smas_pkg::MODE_ADD;
  smas_pkg::elem_t  a_elem    = '0;
  smas_pkg::elem_t  b_elem    = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [32:0]      value;
  logic [2:0]       row;
  logic [2:0]       col;
  logic             last;

  // Matrix banks and load position as the block should hold them.
  smas_pkg::elem_t  a_matrix [smas_pkg::CELLS];
  smas_pkg::elem_t  b_matrix [smas_pkg::CELLS];
  int unsigned      load_pos = 0;
  cell_word_t       expected_cells [$];

  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  small_matrix_add_sub_mul u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .mode_i      (mode),
    .a_element_i (a_elem),
    .b_element_i (b_elem),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_o     (value),
    .row_o       (row),
    .col_o       (col),
    .last_o      (last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stores one accepted word and, on the last word of a frame, forms the result matrix.
  function automatic void load_and_compute(smas_pkg::mode_e op, smas_pkg::elem_t a,
                                           smas_pkg::elem_t b);
    longint      acc;
    cell_word_t  exp_word;
    int unsigned pos;
    a_matrix[load_pos] = a;
    b_matrix[load_pos] = b;
    if (load_pos + 1 < smas_pkg::CELLS) begin
      load_pos++;
      return;
    end
    load_pos = 0;
    for (int r = 0; r < smas_pkg::SIZE; r++) begin
      for (int c = 0; c < smas_pkg::SIZE; c++) begin
        pos = r * smas_pkg::SIZE + c;
        case (op)
          smas_pkg::MODE_ADD: begin
            acc = longint'(a_matrix[pos]) + longint'(b_matrix[pos]);
          end
          smas_pkg::MODE_SUB: begin
            acc = longint'(a_matrix[pos]) - longint'(b_matrix[pos]);
          end
          default: begin
            acc = 0;
            for (int k = 0; k < smas_pkg::SIZE; k++) begin
              acc += longint'(a_matrix[r * smas_pkg::SIZE + k]) *
                     longint'(b_matrix[k * smas_pkg::SIZE + c]);
            end
          end
        endcase
        exp_word.value = smas_pkg::value_t'(acc);
        exp_word.row   = 3'(r);
        exp_word.col   = 3'(c);
        exp_word.last  = (pos + 1 == smas_pkg::CELLS);
        expected_cells.push_back(exp_word);
      end
    end
  endfunction

  // Every accepted input word updates the prediction.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      load_and_compute(mode, a_elem, b_elem);
    end
  end

  // Every accepted result word is compared with the oldest expectation.
  always @(posedge clk) begin
    cell_word_t exp_cell;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        $error("unexpected result word: value %0d row %0d col %0d",
               $signed(value), row, col);
        fail_count++;
      end else begin
        exp_cell = expected_cells.pop_front();
        if (value !== exp_cell.value) begin
          $error("value: expected %0d, got %0d", exp_cell.value, $signed(value));
          fail_count++;
        end
        if (row !== exp_cell.row) begin
          $error("row: expected %0d, got %0d", exp_cell.row, row);
          fail_count++;
        end
        if (col !== exp_cell.col) begin
          $error("col: expected %0d, got %0d", exp_cell.col, col);
          fail_count++;
        end
        if (last !== exp_cell.last) begin
          $error("last: expected %0d, got %0d", exp_cell.last, last);
          fail_count++;
        end
      end
    end
  end

  // Receiver: a long hold-off when requested, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offers one word, with a random gap first, and returns once it is accepted.
  // Valid stays high afterwards so back-to-back words need no extra edge.
  task automatic send_word(smas_pkg::mode_e op, smas_pkg::elem_t a, smas_pkg::elem_t b);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    mode     <= op;
    a_elem   <= a;
    b_elem   <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Sends a whole frame; only the final word carries the operation that counts.
  task automatic send_frame(smas_pkg::mode_e op, frame_t a, frame_t b);
    for (int i = 0; i < smas_pkg::CELLS; i++) begin
      if (i + 1 == smas_pkg::CELLS) begin
        send_word(op, a[i], b[i]);
      end else begin
        send_word(smas_pkg::mode_e'($urandom_range(3)), a[i], b[i]);
      end
    end
  endtask

  // Drops valid and waits until every expected result word has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Picks an element: full range, extreme values, or small values.
  function automatic smas_pkg::elem_t pick_elem(int unsigned flavor);
    case (flavor)
      0: return smas_pkg::elem_t'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return ELEM_MAX;
          1: return ELEM_MIN;
          2: return smas_pkg::elem_t'(0);
          3: return smas_pkg::elem_t'(-1);
          default: return smas_pkg::elem_t'(1);
        endcase
      end
      default: return smas_pkg::elem_t'($signed($urandom_range(15)) - 8);
    endcase
  endfunction

  // Sums and differences at the corners of the element range.
  task automatic test_add_sub_extremes();
    frame_t a;
    frame_t b;
    for (int i = 0; i < smas_pkg::CELLS; i++) begin
      a[i] = (i % 2) ? ELEM_MIN : ELEM_MAX;
      b[i] = ((i / 2) % 2) ? ELEM_MIN : ELEM_MAX;
    end
    send_frame(smas_pkg::MODE_ADD, a, b);
    send_frame(smas_pkg::MODE_SUB, a, b);
  endtask

  // Products at the extremes, also through the alternate product code.
  task automatic test_product_extremes();
    frame_t a;
    frame_t b;
    for (int i = 0; i < smas_pkg::CELLS; i++) begin
      a[i] = ELEM_MIN;
      b[i] = ELEM_MIN;
    end
    send_frame(smas_pkg::MODE_MUL, a, b);
    for (int i = 0; i < smas_pkg::CELLS; i++) begin
      a[i] = ELEM_MAX;
      b[i] = ELEM_MIN;
    end
    send_frame(smas_pkg::MODE_MUL_ALT, a, b);
    wait_drained();
  endtask

  // Random frames with random operation under the given idling.
  task automatic test_random_frames(int unsigned gap_pct, int unsigned stall_pct);
    frame_t      a;
    frame_t      b;
    int unsigned flavor;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      flavor = $urandom_range(3);
      for (int i = 0; i < smas_pkg::CELLS; i++) begin
        a[i] = pick_elem(flavor);
        b[i] = pick_elem(flavor);
      end
      send_frame(smas_pkg::mode_e'($urandom_range(3)), a, b);
    end
    wait_drained();
  endtask

  // The receiver holds off while frames keep coming, so both banks fill and
  // the input stalls.
  task automatic test_backpressure();
    frame_t a;
    frame_t b;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    for (int f = 0; f < 3; f++) begin
      for (int i = 0; i < smas_pkg::CELLS; i++) begin
        a[i] = pick_elem(0);
        b[i] = pick_elem(0);
      end
      send_frame(smas_pkg::mode_e'($urandom_range(3)), a, b);
    end
    wait_drained();
  endtask

  initial begin
    send_gap_pct   = 28;
    recv_stall_pct = 56;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_add_sub_extremes();
    test_product_extremes();
    test_random_frames(28, 56);
    test_random_frames(56, 28);
    test_backpressure();
    test_random_frames(0, 0);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/smas_pkg.sv
design/smas_front.sv
design/smas_cmd_fifo.sv
design/smas_back.sv
design/small_matrix_add_sub_mul.sv
test/tb.sv
